// File: hw/rtl/rbfm_pkg.sv
package rbfm_pkg;

    localparam int CHANNELS = 24;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = 8;
    localparam int MSG_W = 8;
    localparam int CMD_W = 8;
    localparam int OP_W = 2;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CLEAR_COUNT_RESET = 8'd150;

    localparam logic [OP_W-1:0] OP_COMMAND = 2'd0;
    localparam logic [OP_W-1:0] OP_CURRENT = 2'd1;
    localparam logic [OP_W-1:0] OP_SUPPLY = 2'd2;

    localparam logic [CMD_W-1:0] CMD_ALL_OFF = 8'hF0;
    localparam logic [CMD_W-1:0] CMD_SINGLE_LIMIT = 8'h40;

    localparam logic [MSG_W-1:0] MSG_FAULT_SET = 8'hC0;
    localparam logic [MSG_W-1:0] MSG_FAULT_CLR = 8'hA0;
    localparam logic [MSG_W-1:0] MSG_MAIN_RISE = 8'h70;
    localparam logic [MSG_W-1:0] MSG_MAIN_FALL = 8'h60;
    localparam logic [MSG_W-1:0] MSG_AUX_RISE = 8'h71;
    localparam logic [MSG_W-1:0] MSG_AUX_FALL = 8'h61;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FAULT_RPT,
        ST_SUP_RPT
    } rbfm_state_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
    } cnt_rd_t;

    typedef struct packed {
        logic             en;
        logic [CH_W-1:0]  addr;
        logic [CNT_W-1:0] data;
    } cnt_wr_t;

endpackage

// File: hw/rtl/rbfm_if.sv
interface rbfm_req_if;
    import rbfm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CMD_W-1:0]    command_byte;
    logic [CHANNELS-1:0] current_sense;
    logic                supply_main;
    logic                supply_aux;

    modport source (
        output valid, operation, command_byte, current_sense, supply_main, supply_aux,
        input  ready
    );
    modport sink (
        input  valid, operation, command_byte, current_sense, supply_main, supply_aux,
        output ready
    );
endinterface

interface rbfm_rsp_if;
    import rbfm_pkg::*;

    logic                valid;
    logic                ready;
    logic                msg_valid;
    logic [MSG_W-1:0]    msg_byte;
    logic [CHANNELS-1:0] relay_drive;
    logic                last;

    modport source (
        output valid, msg_valid, msg_byte, relay_drive, last,
        input  ready
    );
    modport sink (
        input  valid, msg_valid, msg_byte, relay_drive, last,
        output ready
    );
endinterface

interface rbfm_cfg_if;
    import rbfm_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: hw/rtl/rbfm_count_ram.sv
module rbfm_count_ram
    import rbfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  cnt_rd_t          rd,
    input  cnt_wr_t          wr,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [CNT_W-1:0]    rd_data_reg;

    // An entry that has not been written since reset or the last clear reads as zero.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= valid_reg[rd.addr] ? mem[rd.addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/relay_bank_fault_monitor_unit.sv
// Channel  Direction  Width (payload)   Contents
// req      in         2+8+24+1+1        operation, command_byte, current_sense, supply levels
// rsp      out        1+8+24+1          msg_valid, msg_byte, relay_drive, last
// cfg      in         8                 fault_clear_count
//
// One item is handled at a time; req is ready only while the block is idle.
// A command gives one empty beat; a supply sample gives one beat per level change,
// or one empty beat. A current sample reads the 24 good-count RAM entries, one per cycle
// from a registered read port, then gives two beats per changed fault flag (up to 48).
// Reset clears all control state and sets fault_clear_count to 150.
// A stalled rsp holds the output register and pauses report generation.
module relay_bank_fault_monitor_unit
    import rbfm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rbfm_req_if.sink   req,
    rbfm_rsp_if.source rsp,
    rbfm_cfg_if.sink   cfg
);

    rbfm_state_t         state_reg, state_next;
    logic [CHANNELS-1:0] relay_on_reg, relay_on_next;
    logic [CHANNELS-1:0] fault_flag_reg, fault_flag_next;
    logic [CHANNELS-1:0] fault_rep_reg, fault_rep_next;
    logic [CHANNELS-1:0] sense_reg, sense_next;
    logic [1:0]          supply_prev_reg, supply_prev_next;
    logic [1:0]          sup_pend_reg, sup_pend_next;
    logic [1:0]          sup_lvl_reg, sup_lvl_next;
    logic [CNT_W-1:0]    clear_cnt_reg;
    logic [CH_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                issue_reg, issue_next;
    logic                s1_valid_reg, s1_valid_next;
    logic [CH_W-1:0]     s1_idx_reg, s1_idx_next;
    logic                dup_reg, dup_next;

    logic                out_valid_reg, out_valid_next;
    logic                msg_valid_reg, msg_valid_next;
    logic [MSG_W-1:0]    msg_byte_reg, msg_byte_next;
    logic [CHANNELS-1:0] drive_reg, drive_next;
    logic                last_reg, last_next;

    cnt_rd_t             cnt_rd;
    cnt_wr_t             cnt_wr;
    logic                cnt_clear;
    logic [CNT_W-1:0]    cnt_data;
    logic [CNT_W-1:0]    cnt_inc;

    logic                accept;
    logic                emit_go;
    logic [CHANNELS-1:0] diff;
    logic [CHANNELS-1:0] low_bit;
    logic [CHANNELS-1:0] rest;
    logic [CH_W-1:0]     low_idx;
    logic [CHANNELS-1:0] cmd_bit;
    logic [MSG_W-1:0]    fault_code;

    rbfm_count_ram u_count_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cnt_clear),
        .rd      (cnt_rd),
        .wr      (cnt_wr),
        .rd_data (cnt_data)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign emit_go = ((state_reg == ST_FAULT_RPT) || (state_reg == ST_SUP_RPT))
                     && (!out_valid_reg || rsp.ready);

    assign diff    = fault_flag_reg ^ fault_rep_reg;
    assign low_bit = diff & (~diff + CHANNELS'(1));
    assign rest    = diff & ~low_bit;
    assign cnt_inc = (cnt_data == CNT_MAX) ? cnt_data : cnt_data + CNT_W'(1);
    assign cmd_bit = CHANNELS'(1) << req.command_byte[4:0];

    always_comb
    begin
        low_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (diff[i])
            begin
                low_idx = CH_W'(i);
            end
        end
    end

    assign fault_code = (fault_flag_reg[low_idx] ? MSG_FAULT_SET : MSG_FAULT_CLR)
                        | MSG_W'(low_idx);

    always_comb
    begin
        state_next       = state_reg;
        relay_on_next    = relay_on_reg;
        fault_flag_next  = fault_flag_reg;
        fault_rep_next   = fault_rep_reg;
        sense_next       = sense_reg;
        supply_prev_next = supply_prev_reg;
        sup_pend_next    = sup_pend_reg;
        sup_lvl_next     = sup_lvl_reg;
        rd_idx_next      = rd_idx_reg;
        issue_next       = issue_reg;
        s1_valid_next    = 1'b0;
        s1_idx_next      = s1_idx_reg;
        dup_next         = dup_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        msg_valid_next   = msg_valid_reg;
        msg_byte_next    = msg_byte_reg;
        drive_next       = drive_reg;
        last_next        = last_reg;
        cnt_rd           = '{en: 1'b0, addr: rd_idx_reg};
        cnt_wr           = '{en: 1'b0, addr: s1_idx_reg, data: '0};
        cnt_clear        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sup_pend_next = 2'b00;
                    state_next    = ST_SUP_RPT;
                    case (req.operation)
                        OP_COMMAND:
                        begin
                            if (req.command_byte == CMD_ALL_OFF)
                            begin
                                relay_on_next   = '0;
                                fault_flag_next = '0;
                                fault_rep_next  = '0;
                                cnt_clear       = 1'b1;
                            end
                            else if (req.command_byte < CMD_SINGLE_LIMIT
                                     && 32'(req.command_byte[4:0]) < CHANNELS)
                            begin
                                if (req.command_byte[5])
                                begin
                                    relay_on_next = relay_on_reg | cmd_bit;
                                end
                                else
                                begin
                                    relay_on_next = relay_on_reg & ~cmd_bit;
                                end
                            end
                        end
                        OP_CURRENT:
                        begin
                            sense_next  = req.current_sense;
                            rd_idx_next = '0;
                            issue_next  = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        OP_SUPPLY:
                        begin
                            sup_pend_next[0] = req.supply_main != supply_prev_reg[0];
                            sup_pend_next[1] = req.supply_aux != supply_prev_reg[1];
                            sup_lvl_next     = {req.supply_aux, req.supply_main};
                            supply_prev_next = {req.supply_aux, req.supply_main};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    cnt_rd.en     = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_idx_next   = rd_idx_reg;
                    if (rd_idx_reg == CH_LAST)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + CH_W'(1);
                    end
                end
                if (s1_valid_reg)
                begin
                    if (relay_on_reg[s1_idx_reg])
                    begin
                        cnt_wr.en = 1'b1;
                        if (!sense_reg[s1_idx_reg])
                        begin
                            fault_flag_next[s1_idx_reg] = 1'b1;
                            cnt_wr.data                 = '0;
                        end
                        else
                        begin
                            cnt_wr.data = cnt_inc;
                            if (cnt_inc >= clear_cnt_reg)
                            begin
                                fault_flag_next[s1_idx_reg] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        fault_flag_next[s1_idx_reg] = 1'b0;
                    end
                    if (s1_idx_reg == CH_LAST)
                    begin
                        dup_next   = 1'b0;
                        state_next = ST_FAULT_RPT;
                    end
                end
            end

            ST_FAULT_RPT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = relay_on_reg;
                    if (diff == '0)
                    begin
                        msg_valid_next = 1'b0;
                        msg_byte_next  = '0;
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        msg_valid_next = 1'b1;
                        msg_byte_next  = fault_code;
                        if (!dup_reg)
                        begin
                            dup_next  = 1'b1;
                            last_next = 1'b0;
                        end
                        else
                        begin
                            dup_next       = 1'b0;
                            fault_rep_next = fault_rep_reg ^ low_bit;
                            last_next      = (rest == '0);
                            if (rest == '0)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end

            ST_SUP_RPT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = relay_on_reg;
                    if (sup_pend_reg[0])
                    begin
                        msg_valid_next   = 1'b1;
                        msg_byte_next    = sup_lvl_reg[0] ? MSG_MAIN_RISE : MSG_MAIN_FALL;
                        last_next        = !sup_pend_reg[1];
                        sup_pend_next[0] = 1'b0;
                        if (!sup_pend_reg[1])
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else if (sup_pend_reg[1])
                    begin
                        msg_valid_next   = 1'b1;
                        msg_byte_next    = sup_lvl_reg[1] ? MSG_AUX_RISE : MSG_AUX_FALL;
                        last_next        = 1'b1;
                        sup_pend_next[1] = 1'b0;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        msg_valid_next = 1'b0;
                        msg_byte_next  = '0;
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            relay_on_reg    <= '0;
            fault_flag_reg  <= '0;
            fault_rep_reg   <= '0;
            supply_prev_reg <= '0;
            sup_pend_reg    <= '0;
            clear_cnt_reg   <= CLEAR_COUNT_RESET;
            rd_idx_reg      <= '0;
            issue_reg       <= 1'b0;
            s1_valid_reg    <= 1'b0;
            dup_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            relay_on_reg    <= relay_on_next;
            fault_flag_reg  <= fault_flag_next;
            fault_rep_reg   <= fault_rep_next;
            supply_prev_reg <= supply_prev_next;
            sup_pend_reg    <= sup_pend_next;
            rd_idx_reg      <= rd_idx_next;
            issue_reg       <= issue_next;
            s1_valid_reg    <= s1_valid_next;
            dup_reg         <= dup_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                clear_cnt_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sense_reg     <= sense_next;
        sup_lvl_reg   <= sup_lvl_next;
        s1_idx_reg    <= s1_idx_next;
        msg_valid_reg <= msg_valid_next;
        msg_byte_reg  <= msg_byte_next;
        drive_reg     <= drive_next;
        last_reg      <= last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.msg_valid   = msg_valid_reg;
    assign rsp.msg_byte    = msg_byte_reg;
    assign rsp.relay_drive = drive_reg;
    assign rsp.last        = last_reg;

`ifndef SYNTHESIS
    a_no_write_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_SCAN |-> !cnt_wr.en)
        else $error("good-count RAM written outside the scan");

    a_stage_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> state_reg == ST_SCAN)
        else $error("scan stage active outside the scan");

    a_second_copy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FAULT_RPT && dup_reg) |-> diff != '0)
        else $error("second fault report copy without a pending change");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.msg_valid) |-> rsp.last)
        else $error("empty result beat not marked last");
`endif

endmodule
